FILE: rtl/rle_pkg.sv
// Package for the skip/repeat/literal run-length line decoder.
// Request types, decoder phase and sequencer codes, control byte masks.
// No dependencies.
package rle_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       line_last;
    logic       frame_first;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic [7:0] pixel_colour;
    logic       run_last;
  } out_req_t;

  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_COLOUR  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef enum logic {
    SEQ_ACCEPT = 1'b0,
    SEQ_RUN    = 1'b1
  } seq_e;

  typedef struct packed {
    logic at_end;
    logic last_col;
  } col_stat_t;

  localparam logic [7:0] CtrlSkipMask   = 8'h01;
  localparam logic [7:0] CtrlRepeatMask = 8'h02;
  localparam int unsigned RunWidth      = 7;

endpackage

FILE: rtl/rle_col_unit.sv
// Shared column unit: saturating add of a step to the column counter,
// plus end-of-line status flags. Depends on rle_pkg.
module rle_col_unit #(
  parameter int LINE_WIDTH = 256
) (
  input  logic [$clog2(LINE_WIDTH+1)-1:0] col_i,
  input  logic [rle_pkg::RunWidth-1:0]    step_i,
  output logic [$clog2(LINE_WIDTH+1)-1:0] col_o,
  output rle_pkg::col_stat_t              stat_o
);
  import rle_pkg::*;

  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam int SW = ((CW > RunWidth) ? CW : RunWidth) + 1;
  localparam logic [SW-1:0] LwS    = LINE_WIDTH[SW-1:0];
  localparam logic [SW-1:0] LwLast = LINE_WIDTH[SW-1:0] - SW'(1);

  logic [SW-1:0] col_ext;
  logic [SW-1:0] sum;

  always_comb begin
    col_ext         = SW'(col_i);
    sum             = col_ext + SW'(step_i);
    stat_o.at_end   = (col_ext >= LwS);
    stat_o.last_col = (col_ext == LwLast);
    if (stat_o.at_end || (sum >= LwS)) begin
      col_o = LwS[CW-1:0];
    end else begin
      col_o = sum[CW-1:0];
    end
  end

endmodule

FILE: rtl/rle_line_skip_repeat_literal_decoder_top.sv
// Top level of the skip/repeat/literal run-length line decoder.
// Depends on rle_pkg and rle_col_unit.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_req_i  (rle_pkg::in_req_t)
//  out     | output    | out_valid_o/out_stall_i | out_req_o (rle_pkg::out_req_t)
//
// Control and literal bytes are each handled as they are accepted; a literal pixel is loaded
// into the output register at the edge that accepts its byte.
// A repeat colour byte writes n pixels (n <= 64), one adder step per pixel while the output
// is not stalled, and none when the column is already past the line.
// Reset clears phase, run count, column and row; no clearing pass.
// Output stall holds the output register and stalls the input.
module rle_line_skip_repeat_literal_decoder_top #(
  parameter int LINE_WIDTH = 256,
  parameter int MAX_ROWS   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rle_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rle_pkg::out_req_t out_req_o
);
  import rle_pkg::*;

  localparam int CW = $clog2(LINE_WIDTH + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [RW-1:0] RowMax = MAX_ROWS[RW-1:0] - RW'(1);

  seq_e                phase_seq_q, phase_seq_d;
  phase_e              phase_q, phase_d;
  logic [RunWidth-1:0] run_q, run_d;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic                pend_line_q, pend_line_d;
  logic [7:0]          colour_q, colour_d;
  logic                out_valid_q, out_valid_d;
  out_req_t            out_q, out_d;

  logic [RunWidth-1:0] step;
  logic [CW-1:0]       col_sum;
  col_stat_t           col_stat;
  logic                out_free;
  logic                accept;
  logic                emit;
  logic                pix_last;
  logic [RW-1:0]       row_n;

  rle_col_unit #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_col (
    .col_i (col_q),
    .step_i(step),
    .col_o (col_sum),
    .stat_o(col_stat)
  );

  // handshake
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (phase_seq_q == SEQ_RUN) || !out_free;
    accept     = in_valid_i && !in_stall_o;
  end

  // adder step select
  always_comb begin
    if ((phase_seq_q == SEQ_ACCEPT) && (phase_q != PH_COLOUR) && (phase_q != PH_LITERAL)) begin
      step = in_req_i.code_byte[7:1];
    end else begin
      step = RunWidth'(1);
    end
  end

  // next state
  always_comb begin
    phase_seq_d = phase_seq_q;
    phase_d     = phase_q;
    run_d       = run_q;
    col_d       = col_q;
    row_d       = row_q;
    pend_line_d = pend_line_q;
    colour_d    = colour_q;
    emit        = 1'b0;
    pix_last    = 1'b0;
    row_n       = row_q;
    case (phase_seq_q)
      SEQ_ACCEPT: begin
        if (accept) begin
          row_n = in_req_i.frame_first ? '0 : row_q;
          row_d = row_n;
          case (phase_q)
            PH_COLOUR: begin
              colour_d    = in_req_i.code_byte;
              pend_line_d = in_req_i.line_last;
              phase_d     = PH_CTRL;
              phase_seq_d = SEQ_RUN;
            end
            PH_LITERAL: begin
              colour_d = in_req_i.code_byte;
              emit     = !col_stat.at_end;
              pix_last = 1'b1;
              col_d    = col_sum;
              if (run_q > RunWidth'(1)) begin
                run_d = run_q - RunWidth'(1);
              end else begin
                run_d   = '0;
                phase_d = PH_CTRL;
              end
            end
            default: begin
              if ((in_req_i.code_byte & CtrlSkipMask) != '0) begin
                col_d   = col_sum;
                phase_d = PH_CTRL;
                run_d   = '0;
              end else if ((in_req_i.code_byte & CtrlRepeatMask) != '0) begin
                run_d   = RunWidth'(in_req_i.code_byte[7:2]) + RunWidth'(1);
                phase_d = PH_COLOUR;
              end else begin
                run_d   = RunWidth'(in_req_i.code_byte[7:2]) + RunWidth'(1);
                phase_d = PH_LITERAL;
              end
            end
          endcase
          if (in_req_i.line_last && (phase_q != PH_COLOUR)) begin
            col_d   = '0;
            phase_d = PH_CTRL;
            run_d   = '0;
            row_d   = (row_n < RowMax) ? row_n + RW'(1) : row_n;
          end
        end
      end
      SEQ_RUN: begin
        if (!col_stat.at_end && out_free) begin
          emit     = 1'b1;
          pix_last = (run_q == RunWidth'(1)) || col_stat.last_col;
          col_d    = col_sum;
          run_d    = run_q - RunWidth'(1);
        end
        if (col_stat.at_end || (emit && pix_last)) begin
          phase_seq_d = SEQ_ACCEPT;
          run_d       = '0;
          if (pend_line_q) begin
            col_d = '0;
            row_d = (row_q < RowMax) ? row_q + RW'(1) : row_q;
          end
        end
      end
      default: begin
        phase_seq_d = SEQ_ACCEPT;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d        = 1'b1;
      out_d.pixel_column = 8'(col_q);
      out_d.pixel_row    = 8'(row_n);
      out_d.pixel_colour = (phase_seq_q == SEQ_RUN) ? colour_q : in_req_i.code_byte;
      out_d.run_last     = pix_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_seq_q <= SEQ_ACCEPT;
      phase_q     <= PH_CTRL;
      run_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pend_line_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_seq_q <= phase_seq_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_line_q <= pend_line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    colour_q <= colour_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/rle_checker.sv
// Port-level checker for the run-length line decoder, with its bind.
// Depends on rle_pkg and rle_line_skip_repeat_literal_decoder_top.
module rle_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rle_pkg::out_req_t out_req_o
);
  import rle_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // stall input while a result is blocked
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

  // keep input stalled inside a repeat run
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_req_o.run_last |-> in_stall_o)
    else $error("input taken in the middle of a run");

endmodule

bind rle_line_skip_repeat_literal_decoder_top rle_checker u_rle_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_req_o  (out_req_o)
);
